// ===== design/kteq_pkg.sv =====
// Package for the keypad and trackball event qualifier.
// Holds event codes, register indexes, key codes, reset values and the
// structs passed between modules. No dependencies.
package kteq_pkg;

  localparam int TimeW  = 32;
  localparam int MsW    = 10;
  localparam int StepW  = 7;
  localparam int PinW   = 5;
  localparam int PinClk = 4;

  typedef enum logic [3:0] {
    EV_NONE   = 4'd0,
    EV_CHAR   = 4'd1,
    EV_OK     = 4'd2,
    EV_BACK   = 4'd3,
    EV_UP     = 4'd4,
    EV_DOWN   = 4'd5,
    EV_LEFT   = 4'd6,
    EV_RIGHT  = 4'd7,
    EV_CURSOR = 4'd8
  } event_t;

  typedef enum logic [2:0] {
    REG_TEXT_ENTRY   = 3'd0,
    REG_RIGHT_HANDED = 3'd1,
    REG_CURSOR_MODE  = 3'd2,
    REG_KEY_POLL     = 3'd3,
    REG_CLICK_HOLD   = 3'd4,
    REG_NAV_HOLD     = 3'd5,
    REG_CURSOR_STEP  = 3'd6
  } cfg_reg_t;

  localparam logic [7:0] KEY_NUL   = 8'h00;
  localparam logic [7:0] KEY_NOKEY = 8'hFF;
  localparam logic [7:0] KEY_BS    = 8'h08;
  localparam logic [7:0] KEY_LF    = 8'h0A;
  localparam logic [7:0] KEY_CR    = 8'h0D;
  localparam logic [7:0] KEY_ESC   = 8'h1B;
  localparam logic [7:0] KEY_SPACE = 8'h20;
  localparam logic [7:0] KEY_DEL   = 8'h7F;
  localparam logic [7:0] KEY_LEFT  = 8'hB4;
  localparam logic [7:0] KEY_DOWN  = 8'hB5;
  localparam logic [7:0] KEY_UP    = 8'hB6;
  localparam logic [7:0] KEY_RIGHT = 8'hB7;

  // lower-case letter codes for the arrow keys
  localparam logic [7:0] KEY_LC_W  = 8'h77;
  localparam logic [7:0] KEY_LC_A  = 8'h61;
  localparam logic [7:0] KEY_LC_S  = 8'h73;
  localparam logic [7:0] KEY_LC_D  = 8'h64;
  localparam logic [7:0] KEY_LC_I  = 8'h69;
  localparam logic [7:0] KEY_LC_J  = 8'h6A;
  localparam logic [7:0] KEY_LC_K  = 8'h6B;
  localparam logic [7:0] KEY_LC_L  = 8'h6C;

  localparam logic [MsW-1:0]   KEY_POLL_RST   = 10'd50;
  localparam logic [MsW-1:0]   CLICK_HOLD_RST = 10'd80;
  localparam logic [MsW-1:0]   NAV_HOLD_RST   = 10'd30;
  localparam logic [StepW-1:0] STEP_RST       = 7'd4;
  localparam logic [PinW-1:0]  LEVELS_IDLE    = 5'h1F;

  typedef struct packed {
    logic             text_entry_mode;
    logic             right_handed;
    logic             cursor_mode;
    logic [MsW-1:0]   key_poll_ms;
    logic [MsW-1:0]   click_holdoff_ms;
    logic [MsW-1:0]   nav_holdoff_ms;
    logic [StepW-1:0] cursor_step;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             key_valid;
    logic [7:0]       key_byte;
    logic [PinW-1:0]  ball_levels;
  } item_t;

  typedef struct packed {
    event_t      event_res;
    logic [7:0]  key_char;
    logic signed [7:0] cursor_dx;
    logic signed [7:0] cursor_dy;
    logic        key_taken;
  } res_t;

endpackage

// ===== design/keypad_trackball_event_qualifier.sv =====
// Top level of the keypad and trackball event qualifier: config registers,
// input register, result register. Depends on kteq_pkg and kteq_core.
//
// Usage: each poll is one item on the in_ stream; exactly one result item
// per poll leaves on the out_ stream, in order. The input tdata carries the
// poll time, the keyboard byte and the five active-low trackball levels;
// in_tuser flags that the keyboard offers a byte. The result carries the
// event code, the keyboard byte, the signed cursor step and key_taken.
// An accepted item is evaluated against the timing state combinationally,
// and its result is registered in the result register behind out_tvalid.
// Throughput: one item per clock while the receiver does not stall; the poll
// evaluation is one register stage of compare-and-update logic, so state
// written by one item is seen by the next one.
// Reset (rst_n low, synchronous): both streams empty, registers back to
// their defaults, all stored times zero and all pins released.
// When the receiver stalls, the result holds, the input register still
// fills, and in_tready drops once both are full.
// Configuration writes are taken on any cycle cfg_we is high; write only
// while the block is idle.
module keypad_trackball_event_qualifier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // now_ms[31:0], key_byte[39:32], ball_levels[44:40]
  input  logic        in_tuser,   // key_valid
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // event_res[3:0], key_char[11:4], cursor_dx[19:12],
                                  // cursor_dy[27:20], key_taken[28]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [9:0]  cfg_wdata
);
  import kteq_pkg::*;

  cfg_t  cfg_r;
  item_t item_r;
  res_t  res_r, res;
  logic  in_valid_r, out_valid_r;
  logic  advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.text_entry_mode  <= 1'b0;
      cfg_r.right_handed     <= 1'b0;
      cfg_r.cursor_mode      <= 1'b0;
      cfg_r.key_poll_ms      <= KEY_POLL_RST;
      cfg_r.click_holdoff_ms <= CLICK_HOLD_RST;
      cfg_r.nav_holdoff_ms   <= NAV_HOLD_RST;
      cfg_r.cursor_step      <= STEP_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TEXT_ENTRY:   cfg_r.text_entry_mode  <= cfg_wdata[0];
        REG_RIGHT_HANDED: cfg_r.right_handed     <= cfg_wdata[0];
        REG_CURSOR_MODE:  cfg_r.cursor_mode      <= cfg_wdata[0];
        REG_KEY_POLL:     cfg_r.key_poll_ms      <= cfg_wdata;
        REG_CLICK_HOLD:   cfg_r.click_holdoff_ms <= cfg_wdata;
        REG_NAV_HOLD:     cfg_r.nav_holdoff_ms   <= cfg_wdata;
        REG_CURSOR_STEP:  cfg_r.cursor_step      <= cfg_wdata[StepW-1:0];
        default: ;
      endcase
    end
  end

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.now_ms      <= in_tdata[31:0];
      item_r.key_valid   <= in_tuser;
      item_r.key_byte    <= in_tdata[39:32];
      item_r.ball_levels <= in_tdata[44:40];
    end
  end

  kteq_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .item    (item_r),
    .advance (advance),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, res_r.key_taken, res_r.cursor_dy, res_r.cursor_dx,
                       res_r.key_char, res_r.event_res};

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("evaluated item did not reach the result register");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !in_valid_r)
    else $error("streams not empty after reset");

  a_char_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.key_char != 8'd0) |->
      (res_r.event_res != EV_NONE && res_r.event_res != EV_CURSOR && res_r.key_taken))
    else $error("key byte on a non-keyboard result");

endmodule

// ===== design/kteq_key_map.sv =====
// Keyboard byte to navigation event mapping.
// Depends on kteq_pkg.
module kteq_key_map (
  input  logic [7:0]      key_byte,
  input  logic            text_entry_mode,
  input  logic            right_handed,
  output kteq_pkg::event_t key_event
);
  import kteq_pkg::*;

  // lower-case fold, only compared against letters
  logic [7:0] folded;
  assign folded = key_byte | 8'h20;

  always_comb begin
    key_event = EV_CHAR;
    case (key_byte)
      KEY_LF, KEY_CR:           key_event = EV_OK;
      KEY_BS, KEY_DEL, KEY_ESC: key_event = EV_BACK;
      KEY_LEFT:                 key_event = EV_LEFT;
      KEY_DOWN:                 key_event = EV_DOWN;
      KEY_UP:                   key_event = EV_UP;
      KEY_RIGHT:                key_event = EV_RIGHT;
      default: begin
        if (text_entry_mode) begin
          key_event = EV_CHAR;
        end else if (key_byte == KEY_SPACE) begin
          key_event = EV_OK;
        end else if (right_handed) begin
          case (folded)
            KEY_LC_I: key_event = EV_UP;
            KEY_LC_K: key_event = EV_DOWN;
            KEY_LC_J: key_event = EV_LEFT;
            KEY_LC_L: key_event = EV_RIGHT;
            default:  key_event = EV_CHAR;
          endcase
        end else begin
          case (folded)
            KEY_LC_W: key_event = EV_UP;
            KEY_LC_S: key_event = EV_DOWN;
            KEY_LC_A: key_event = EV_LEFT;
            KEY_LC_D: key_event = EV_RIGHT;
            default:  key_event = EV_CHAR;
          endcase
        end
      end
    endcase
  end

endmodule

// ===== design/kteq_core.sv =====
// Poll evaluation: timing state, key gate, click and arrow edge checks.
// Depends on kteq_pkg and kteq_key_map.
module kteq_core (
  input  logic            clk,
  input  logic            rst_n,
  input  kteq_pkg::cfg_t  cfg,
  input  kteq_pkg::item_t item,
  input  logic            advance,
  output kteq_pkg::res_t  res
);
  import kteq_pkg::*;

  logic [TimeW-1:0] last_key_time_r, last_key_time_nxt;
  logic [TimeW-1:0] last_click_time_r, last_click_time_nxt;
  logic [TimeW-1:0] last_nav_time_r, last_nav_time_nxt;
  logic [PinW-1:0]  last_levels_r, last_levels_nxt;

  logic [TimeW-1:0] key_el, click_el, nav_el;
  logic key_open, click_ok, nav_ok;
  logic key_hit, click_hit, scan, hit_any;
  logic [1:0] hit_idx;
  logic [7:0] step8;
  event_t key_event;

  kteq_key_map u_key_map (
    .key_byte        (item.key_byte),
    .text_entry_mode (cfg.text_entry_mode),
    .right_handed    (cfg.right_handed),
    .key_event       (key_event)
  );

  assign key_el   = item.now_ms - last_key_time_r;
  assign click_el = item.now_ms - last_click_time_r;
  assign nav_el   = item.now_ms - last_nav_time_r;
  assign key_open = key_el   > {{(TimeW-MsW){1'b0}}, cfg.key_poll_ms};
  assign click_ok = click_el > {{(TimeW-MsW){1'b0}}, cfg.click_holdoff_ms};
  assign nav_ok   = nav_el   > {{(TimeW-MsW){1'b0}}, cfg.nav_holdoff_ms};

  assign key_hit = key_open && item.key_valid &&
                   item.key_byte != KEY_NUL && item.key_byte != KEY_NOKEY;
  assign click_hit = !key_hit && !item.ball_levels[PinClk] &&
                     last_levels_r[PinClk] && click_ok;
  assign scan = !key_hit && !click_hit;
  assign step8 = {1'b0, cfg.cursor_step};

  // arrows in order up, right, down, left; pins past the hit stay as they are
  always_comb begin
    last_levels_nxt = last_levels_r;
    hit_any = 1'b0;
    hit_idx = 2'd0;
    if (!key_hit) begin
      last_levels_nxt[PinClk] = item.ball_levels[PinClk];
    end
    for (int i = 0; i < 4; i++) begin
      if (scan && !hit_any) begin
        last_levels_nxt[i] = item.ball_levels[i];
        if (last_levels_r[i] && !item.ball_levels[i] && nav_ok) begin
          hit_any = 1'b1;
          hit_idx = 2'(i);
        end
      end
    end
  end

  always_comb begin
    res.event_res = EV_NONE;
    res.key_char  = 8'd0;
    res.cursor_dx = 8'sd0;
    res.cursor_dy = 8'sd0;
    res.key_taken = key_open && item.key_valid;
    if (key_hit) begin
      res.event_res = key_event;
      res.key_char  = item.key_byte;
    end else if (click_hit) begin
      res.event_res = EV_OK;
    end else if (hit_any) begin
      if (cfg.cursor_mode) begin
        res.event_res = EV_CURSOR;
        case (hit_idx)
          2'd0:    res.cursor_dy = -$signed(step8);
          2'd1:    res.cursor_dx = $signed(step8);
          2'd2:    res.cursor_dy = $signed(step8);
          default: res.cursor_dx = -$signed(step8);
        endcase
      end else begin
        case (hit_idx)
          2'd0:    res.event_res = EV_UP;
          2'd1:    res.event_res = EV_RIGHT;
          2'd2:    res.event_res = EV_DOWN;
          default: res.event_res = EV_LEFT;
        endcase
      end
    end
  end

  assign last_key_time_nxt   = key_open  ? item.now_ms : last_key_time_r;
  assign last_click_time_nxt = click_hit ? item.now_ms : last_click_time_r;
  assign last_nav_time_nxt   = hit_any   ? item.now_ms : last_nav_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_key_time_r   <= '0;
      last_click_time_r <= '0;
      last_nav_time_r   <= '0;
      last_levels_r     <= LEVELS_IDLE;
    end else if (advance) begin
      last_key_time_r   <= last_key_time_nxt;
      last_click_time_r <= last_click_time_nxt;
      last_nav_time_r   <= last_nav_time_nxt;
      last_levels_r     <= last_levels_nxt;
    end
  end

  a_one_axis: assert property (@(posedge clk) disable iff (!rst_n)
    !(res.cursor_dx != 8'sd0 && res.cursor_dy != 8'sd0))
    else $error("cursor step on both axes");

  a_step_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (res.cursor_dx != 8'sd0 || res.cursor_dy != 8'sd0) |-> res.event_res == EV_CURSOR)
    else $error("cursor step without cursor event");

  a_key_time: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res.key_taken) |=> last_key_time_r == $past(item.now_ms))
    else $error("key read time not recorded");

endmodule
